// ===== rtl/att_pkg.sv =====
// Package for the alarm table timer: beat types, codes and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none

package att_pkg;

    localparam int EVENT_W = 8;
    localparam int TIME_W  = 32;
    localparam int DELAY_W = 31;
    localparam int AUX_W   = 32;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRED  = 1'b1;

    localparam logic [1:0] ST_SET       = 2'd0;
    localparam logic [1:0] ST_CANCELLED = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic               operation;
        logic [TIME_W-1:0]  now_ms;
        logic [EVENT_W-1:0] event_id;
        logic [DELAY_W-1:0] delay_ms;
        logic               periodic;
        logic [AUX_W-1:0]   aux_data;
    } req_beat_t;

    typedef struct packed {
        logic               result_kind;
        logic [EVENT_W-1:0] fired_event;
        logic [AUX_W-1:0]   fired_aux;
        logic [1:0]         status;
        logic               overflow_seen;
        logic               last;
    } res_beat_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic fire_now;
        logic pending;
        logic space;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/alarm_table_timer.sv =====
// Top level of the alarm table timer: joins the controller and the datapath.
// Depends on att_pkg, att_controller and att_datapath.
`default_nettype none

// The block holds NUM_ALARMS alarms. A request beat sets, rewrites or cancels
// the alarm for its event and returns one status beat; a tick beat fires every
// due alarm in slot order and returns one beat per fired alarm, or none. Each
// item is accepted, then the table is scanned one slot per cycle through a single
// slot read port unless the result side stalls, and then the item is finished.
// The request side stalls while an item is in progress.
module alarm_table_timer #(
    parameter int NUM_ALARMS = 8
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  att_pkg::req_beat_t  req_beat,
    output logic                res_valid,
    input  wire                 res_stall,
    output att_pkg::res_beat_t  res_beat
);
    import att_pkg::*;

    localparam int IDX_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;

    ctl_cmd_t         cmd;
    dp_status_t       status;
    logic [IDX_W-1:0] idx;

    att_controller #(
        .NUM_ALARMS (NUM_ALARMS),
        .IDX_W      (IDX_W)
    ) u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd),
        .idx       (idx)
    );

    att_datapath #(
        .NUM_ALARMS (NUM_ALARMS),
        .IDX_W      (IDX_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_beat  (req_beat),
        .cmd       (cmd),
        .idx       (idx),
        .status    (status),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res_beat  (res_beat)
    );

endmodule

`default_nettype wire

// ===== rtl/att_datapath.sv =====
// Datapath of the alarm table timer: slot storage, request and tick scan logic,
// the held-back fired result and the output register. Depends on att_pkg.
`default_nettype none

module att_datapath #(
    parameter int NUM_ALARMS = 8,
    parameter int IDX_W      = 3
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  att_pkg::req_beat_t    req_beat,
    input  att_pkg::ctl_cmd_t     cmd,
    input  wire [IDX_W-1:0]       idx,
    output att_pkg::dp_status_t   status,
    input  wire                   res_stall,
    output logic                  res_valid,
    output att_pkg::res_beat_t    res_beat
);
    import att_pkg::*;

    logic                slot_valid_reg    [NUM_ALARMS];
    logic                slot_periodic_reg [NUM_ALARMS];
    logic [EVENT_W-1:0]  slot_event_reg    [NUM_ALARMS];
    logic [AUX_W-1:0]    slot_aux_reg      [NUM_ALARMS];
    logic [TIME_W-1:0]   slot_deadline_reg [NUM_ALARMS];
    logic [DELAY_W-1:0]  slot_reload_reg   [NUM_ALARMS];

    req_beat_t           item_reg;
    logic                match_found_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    match_idx_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic                overflow_reg;
    logic                pending_valid_reg;
    res_beat_t           pending_reg;
    logic                out_valid_reg;
    res_beat_t           out_reg;

    logic                is_tick;
    logic                fire_now;
    logic                hit_now;
    logic                space;
    logic                emit;
    res_beat_t           emit_beat;
    logic                do_write;
    logic                do_cancel;
    logic [IDX_W-1:0]    write_idx;
    logic [1:0]          req_status;

    assign is_tick  = (item_reg.operation == OP_TICK);
    assign fire_now = slot_valid_reg[idx] && (slot_deadline_reg[idx] <= item_reg.now_ms);
    assign hit_now  = slot_valid_reg[idx] && (slot_event_reg[idx] == item_reg.event_id);
    assign space    = !out_valid_reg || !res_stall;

    assign status.is_tick  = is_tick;
    assign status.fire_now = fire_now;
    assign status.pending  = pending_valid_reg;
    assign status.space    = space;

    always_comb
    begin
        do_write   = 1'b0;
        do_cancel  = 1'b0;
        write_idx  = match_found_reg ? match_idx_reg : free_idx_reg;
        req_status = ST_NOT_FOUND;
        if (item_reg.delay_ms != '0)
        begin
            if (match_found_reg || free_found_reg)
            begin
                do_write   = 1'b1;
                req_status = ST_SET;
            end
            else
            begin
                req_status = ST_FULL;
            end
        end
        else if (match_found_reg)
        begin
            do_cancel  = 1'b1;
            req_status = ST_CANCELLED;
        end
    end

    always_comb
    begin
        emit      = 1'b0;
        emit_beat = pending_reg;
        if (cmd.step && is_tick && fire_now && pending_valid_reg)
        begin
            emit = 1'b1;
        end
        else if (cmd.finish && is_tick && pending_valid_reg)
        begin
            emit           = 1'b1;
            emit_beat.last = 1'b1;
        end
        else if (cmd.finish && !is_tick)
        begin
            emit                    = 1'b1;
            emit_beat.result_kind   = KIND_STATUS;
            emit_beat.fired_event   = item_reg.event_id;
            emit_beat.fired_aux     = '0;
            emit_beat.status        = req_status;
            emit_beat.overflow_seen = overflow_reg || (req_status == ST_FULL);
            emit_beat.last          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ALARMS; i++)
            begin
                slot_valid_reg[i]    <= 1'b0;
                slot_periodic_reg[i] <= 1'b0;
            end
            match_found_reg   <= 1'b0;
            free_found_reg    <= 1'b0;
            overflow_reg      <= 1'b0;
            pending_valid_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                match_found_reg   <= 1'b0;
                free_found_reg    <= 1'b0;
                pending_valid_reg <= 1'b0;
            end
            if (cmd.step && is_tick && fire_now)
            begin
                pending_valid_reg <= 1'b1;
                if (!slot_periodic_reg[idx])
                begin
                    slot_valid_reg[idx] <= 1'b0;
                end
            end
            if (cmd.step && !is_tick)
            begin
                if (hit_now && !match_found_reg)
                begin
                    match_found_reg <= 1'b1;
                end
                if (!slot_valid_reg[idx] && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.finish && is_tick)
            begin
                pending_valid_reg <= 1'b0;
            end
            if (cmd.finish && !is_tick)
            begin
                if (do_write)
                begin
                    slot_valid_reg[write_idx]    <= 1'b1;
                    slot_periodic_reg[write_idx] <= item_reg.periodic;
                end
                if (do_cancel)
                begin
                    slot_valid_reg[match_idx_reg] <= 1'b0;
                end
                if (req_status == ST_FULL)
                begin
                    overflow_reg <= 1'b1;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req_beat;
        end
        if (cmd.step && is_tick && fire_now)
        begin
            pending_reg.result_kind   <= KIND_FIRED;
            pending_reg.fired_event   <= slot_event_reg[idx];
            pending_reg.fired_aux     <= slot_aux_reg[idx];
            pending_reg.status        <= ST_SET;
            pending_reg.overflow_seen <= overflow_reg;
            pending_reg.last          <= 1'b0;
            if (slot_periodic_reg[idx])
            begin
                slot_deadline_reg[idx] <= item_reg.now_ms
                                          + {1'b0, slot_reload_reg[idx]};
            end
        end
        if (cmd.step && !is_tick)
        begin
            if (hit_now && !match_found_reg)
            begin
                match_idx_reg <= idx;
            end
            if (!slot_valid_reg[idx] && !free_found_reg)
            begin
                free_idx_reg <= idx;
            end
        end
        if (cmd.finish && do_write)
        begin
            slot_event_reg[write_idx]    <= item_reg.event_id;
            slot_aux_reg[write_idx]      <= item_reg.aux_data;
            slot_deadline_reg[write_idx] <= item_reg.now_ms + {1'b0, item_reg.delay_ms};
            slot_reload_reg[write_idx]   <= item_reg.delay_ms;
        end
        if (emit)
        begin
            out_reg <= emit_beat;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_beat  = out_reg;

endmodule

`default_nettype wire

// ===== rtl/att_controller.sv =====
// Controller of the alarm table timer: sequences load, slot scan and finish.
// Depends on att_pkg.
`default_nettype none

module att_controller #(
    parameter int NUM_ALARMS = 8,
    parameter int IDX_W      = 3
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   req_valid,
    output logic                  req_stall,
    input  att_pkg::dp_status_t   status,
    output att_pkg::ctl_cmd_t     cmd,
    output logic [IDX_W-1:0]      idx
);
    import att_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ALARMS - 1);

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!(status.is_tick && status.fire_now && status.pending && !status.space))
                begin
                    cmd.step = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                if (status.space || (status.is_tick && !status.pending))
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign idx       = idx_reg;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the alarm table timer, with a driver, a monitor and a predictor
// of the alarm table. Depends on att_pkg and alarm_table_timer.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import att_pkg::*;

    localparam int NUM_SLOTS   = 8;
    localparam int LONG_HOLD   = 300;
    localparam int QUIET_LIMIT = 5000;
    localparam int PRINT_LIMIT = 40;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_beat_t req_beat = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_beat_t res_beat;

    req_beat_t beats_to_send[$];
    res_beat_t alarm_results[$];

    logic               slot_on     [NUM_SLOTS];
    logic               slot_repeat [NUM_SLOTS];
    logic [EVENT_W-1:0] slot_ev     [NUM_SLOTS];
    logic [AUX_W-1:0]   slot_word   [NUM_SLOTS];
    logic [TIME_W-1:0]  slot_due    [NUM_SLOTS];
    logic [DELAY_W-1:0] slot_reload [NUM_SLOTS];
    logic               overflow_sticky;

    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_asked = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int          mismatches = 0;
    int          beats_checked = 0;
    logic [31:0] clock_ms = 32'd0;
    int          event_base = 0;

    alarm_table_timer #(.NUM_ALARMS(NUM_SLOTS)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_beat  (req_beat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void advance_alarm_table(input req_beat_t b);
        res_beat_t  held;
        logic       have_held;
        logic [1:0] st;
        int         hit;
        int         i;
        have_held = 1'b0;
        held = '0;
        if (b.operation == OP_TICK)
        begin
            for (i = 0; i < NUM_SLOTS; i++)
            begin
                if (slot_on[i] && slot_due[i] <= b.now_ms)
                begin
                    if (have_held)
                        alarm_results.push_back(held);
                    held = '0;
                    held.result_kind = KIND_FIRED;
                    held.fired_event = slot_ev[i];
                    held.fired_aux = slot_word[i];
                    held.overflow_seen = overflow_sticky;
                    have_held = 1'b1;
                    if (slot_repeat[i])
                        slot_due[i] = b.now_ms + {1'b0, slot_reload[i]};
                    else
                        slot_on[i] = 1'b0;
                end
            end
        end
        else
        begin
            hit = -1;
            for (i = 0; i < NUM_SLOTS; i++)
                if (hit < 0 && slot_on[i] && slot_ev[i] == b.event_id)
                    hit = i;
            if (b.delay_ms != '0)
            begin
                for (i = 0; i < NUM_SLOTS; i++)
                    if (hit < 0 && !slot_on[i])
                        hit = i;
                if (hit >= 0)
                begin
                    slot_on[hit] = 1'b1;
                    slot_repeat[hit] = b.periodic;
                    slot_ev[hit] = b.event_id;
                    slot_word[hit] = b.aux_data;
                    slot_due[hit] = b.now_ms + {1'b0, b.delay_ms};
                    slot_reload[hit] = b.delay_ms;
                    st = ST_SET;
                end
                else
                begin
                    overflow_sticky = 1'b1;
                    st = ST_FULL;
                end
            end
            else if (hit >= 0)
            begin
                slot_on[hit] = 1'b0;
                st = ST_CANCELLED;
            end
            else
                st = ST_NOT_FOUND;
            held.result_kind = KIND_STATUS;
            held.fired_event = b.event_id;
            held.fired_aux = '0;
            held.status = st;
            held.overflow_seen = overflow_sticky;
            have_held = 1'b1;
        end
        if (have_held)
        begin
            held.last = 1'b1;
            alarm_results.push_back(held);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t: result beat %0d: %s is %0h, expected %0h",
                     $realtime, beats_checked, what, got, want);
        mismatches++;
    endtask

    task automatic check_result(input res_beat_t got);
        res_beat_t want;
        if (alarm_results.size() == 0)
        begin
            report_mismatch("unexpected beat, event", 32'(got.fired_event), 32'd0);
        end
        else
        begin
            want = alarm_results.pop_front();
            if (got.result_kind !== want.result_kind)
                report_mismatch("result_kind", 32'(got.result_kind), 32'(want.result_kind));
            if (got.fired_event !== want.fired_event)
                report_mismatch("fired_event", 32'(got.fired_event), 32'(want.fired_event));
            if (got.fired_aux !== want.fired_aux)
                report_mismatch("fired_aux", got.fired_aux, want.fired_aux);
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.overflow_seen !== want.overflow_seen)
                report_mismatch("overflow_seen", 32'(got.overflow_seen),
                                32'(want.overflow_seen));
            if (got.last !== want.last)
                report_mismatch("last", 32'(got.last), 32'(want.last));
        end
        beats_checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_beat <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                advance_alarm_table(req_beat);
            if (!req_valid || !req_stall)
            begin
                if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req_beat <= beats_to_send.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
                check_result(res_beat);
            if (hold_asked != hold_seen)
            begin
                hold_seen <= hold_asked;
                hold_left <= LONG_HOLD;
                res_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                res_stall <= 1'b1;
            end
            else
                res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic queue_request(input logic [31:0] now, input logic [7:0] ev,
                                 input logic [30:0] delay, input logic per,
                                 input logic [31:0] aux);
        req_beat_t b;
        b.operation = OP_REQUEST;
        b.now_ms = now;
        b.event_id = ev;
        b.delay_ms = delay;
        b.periodic = per;
        b.aux_data = aux;
        beats_to_send.push_back(b);
    endtask

    task automatic queue_tick(input logic [31:0] now);
        req_beat_t b;
        b.operation = OP_TICK;
        b.now_ms = now;
        b.event_id = 8'($urandom);
        b.delay_ms = 31'($urandom);
        b.periodic = 1'($urandom);
        b.aux_data = $urandom;
        beats_to_send.push_back(b);
    endtask

    task automatic wait_until_drained();
        while (beats_to_send.size() != 0 || req_valid || alarm_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int count,
                             input logic long_hold);
        int          pick;
        int          n;
        logic [7:0]  ev;
        logic [30:0] delay;
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
        event_base = $urandom_range(245);
        if (long_hold)
            hold_asked++;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            ev = 8'(event_base + $urandom_range(10));
            if ($urandom_range(9) == 0)
                delay = 31'($urandom_range(32'h7FFF_FFFF, 1));
            else
                delay = 31'($urandom_range(40, 1));
            if (pick < 45)
            begin
                clock_ms = clock_ms + $urandom_range(12);
                queue_tick(clock_ms);
            end
            else if (pick < 80)
                queue_request(clock_ms, ev, delay, 1'($urandom), $urandom);
            else if (pick < 95)
                queue_request(clock_ms, ev, 31'd0, 1'($urandom), $urandom);
            else if (pick < 98)
                queue_tick($urandom);
            else
                queue_request($urandom, 8'($urandom), 31'd0, 1'($urandom), $urandom);
        end
        wait_until_drained();
    endtask

    initial
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_on[i] = 1'b0;
            slot_repeat[i] = 1'b0;
            slot_ev[i] = '0;
            slot_word[i] = '0;
            slot_due[i] = '0;
            slot_reload[i] = '0;
        end
        overflow_sticky = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A tick on an empty table, a full table, a rewrite, both cancels and wrapping deadlines.
        queue_tick(32'd0);
        queue_request(32'd0, 8'h00, 31'd1, 1'b1, 32'h0000_0000);
        queue_request(32'd0, 8'hFF, 31'h7FFF_FFFF, 1'b0, 32'hFFFF_FFFF);
        queue_request(32'd0, 8'h55, 31'd3, 1'b0, 32'hA5A5_A5A5);
        queue_request(32'd0, 8'hAA, 31'd5, 1'b1, 32'h5A5A_5A5A);
        queue_request(32'd0, 8'h01, 31'd2, 1'b0, 32'h0000_0001);
        queue_request(32'd0, 8'h02, 31'd4, 1'b0, 32'h0000_0002);
        queue_request(32'd0, 8'h03, 31'd6, 1'b1, 32'h0000_0003);
        queue_request(32'd0, 8'h04, 31'd7, 1'b0, 32'h0000_0004);
        queue_request(32'd0, 8'h77, 31'd9, 1'b0, 32'h0000_0077);
        queue_request(32'd1, 8'h55, 31'd2, 1'b1, 32'h1234_5678);
        queue_request(32'd1, 8'h77, 31'd0, 1'b0, 32'h0000_0000);
        queue_request(32'd1, 8'h02, 31'd0, 1'b1, 32'h0000_0000);
        queue_tick(32'd3);
        queue_request(32'd3, 8'h10, 31'd1, 1'b0, 32'h8000_0000);
        queue_request(32'd3, 8'h11, 31'd1, 1'b1, 32'h7FFF_FFFF);
        queue_tick(32'hFFFF_FFFF);
        queue_request(32'hFFFF_FFF0, 8'h20, 31'h20, 1'b0, 32'hDEAD_BEEF);
        queue_tick(32'd0);
        queue_tick(32'd16);
        run_phase(0, 0, 0, 1'b0);

        clock_ms = 32'd1000;
        run_phase(0, 0, 50, 1'b0);
        run_phase(69, 0, 50, 1'b0);
        run_phase(0, 69, 50, 1'b0);
        run_phase(36, 36, 50, 1'b0);
        run_phase(0, 0, 40, 1'b1);

        repeat (40) @(negedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
